// ===== rtl/rcsu_pkg.sv =====
// Shared types and constants for the readout channel sample unpacker.
// No dependencies; used by rcsu_core and readout_channel_sample_unpacker.
package rcsu_pkg;

	localparam int unsigned WordW   = 16;
	localparam int unsigned SizeW   = 24;
	localparam int unsigned PosW    = 26;
	localparam int unsigned InDataW = 40;   // data_word + payload_size
	localparam int unsigned OutDataW = 48;  // 41 result bits padded to bytes

	localparam logic [PosW-1:0] PosMax      = {PosW{1'b1}};
	localparam logic [PosW-1:0] VersionPos  = PosW'(6);
	localparam logic [PosW-1:0] RegionStart = PosW'(8);
	localparam logic [3:0]      VersionGood = 4'h1;

	localparam logic [2:0] FlavorOne   = 3'd0;
	localparam logic [2:0] FlavorOneB  = 3'd1;
	localparam logic [2:0] FlavorPair  = 3'd2;
	localparam logic [2:0] FlavorSkip  = 3'd7;

	localparam logic KindSample = 1'b0;
	localparam logic KindStray  = 1'b1;

	typedef struct packed {
		logic [WordW-1:0] data_word;
		logic             first_word;
		logic [SizeW-1:0] payload_size;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] channel_id;
		logic [1:0] data_flavor;
		logic [1:0] cap_id;
		logic       start_of_interest;
		logic       sample_ok;
		logic [7:0] adc_value;
		logic [5:0] tdc_leading;
		logic [4:0] tdc_trailing;
		logic [7:0] sample_index;
	} result_t;

endpackage

// ===== rtl/rcsu_core.sv =====
// Per-word decode and payload/channel state of the sample unpacker.
// Depends on rcsu_pkg for the item and result types.
module rcsu_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  rcsu_pkg::item_t item,
	output logic            res_valid,
	output rcsu_pkg::result_t res
);

	logic [rcsu_pkg::PosW-1:0] pos_q, region_end_q;
	logic                      version_good_q, in_channel_q, held_valid_q;
	logic [2:0]                flavor_q;
	logic [7:0]                channel_q;
	logic [1:0]                capid_q;
	logic [15:0]               held_word_q;
	logic [7:0]                count_q;

	logic [rcsu_pkg::PosW-1:0] pos, region_end, pos_d;
	logic                      version_good, in_channel, held_valid;
	logic [2:0]                flavor;
	logic [7:0]                channel;
	logic [1:0]                capid;
	logic [15:0]               held_word;
	logic [7:0]                count;
	logic [15:0]               w;
	logic                      in_region;

	always_comb begin
		w          = item.data_word;
		pos        = item.first_word ? '0 : pos_q;
		if (item.first_word) begin
			region_end = (item.payload_size == '0) ? '0 :
				{rcsu_pkg::PosW'(item.payload_size - 24'd1)} << 2;
		end else begin
			region_end = region_end_q;
		end
		version_good = item.first_word ? 1'b0 : version_good_q;
		in_channel   = item.first_word ? 1'b0 : in_channel_q;
		held_valid   = item.first_word ? 1'b0 : held_valid_q;
		count        = item.first_word ? 8'd0 : count_q;
		flavor       = flavor_q;
		channel      = channel_q;
		capid        = capid_q;
		held_word    = held_word_q;
		res_valid    = 1'b0;
		res          = '0;

		if (pos == rcsu_pkg::VersionPos)
			version_good = (w[15:12] == rcsu_pkg::VersionGood);

		in_region = (pos >= rcsu_pkg::RegionStart) && (pos < region_end);

		if (in_region && version_good) begin
			if (w[15]) begin
				// channel header: open a new channel
				in_channel = 1'b1;
				flavor     = w[14:12];
				channel    = w[7:0];
				capid      = w[9:8];
				held_valid = 1'b0;
				count      = 8'd0;
			end else if (!in_channel) begin
				// stray word: report once, then drop until next header
				res_valid  = 1'b1;
				res.kind   = rcsu_pkg::KindStray;
				in_channel = 1'b1;
				flavor     = rcsu_pkg::FlavorSkip;
				held_valid = 1'b0;
			end else if (flavor == rcsu_pkg::FlavorOne || flavor == rcsu_pkg::FlavorOneB) begin
				res_valid             = 1'b1;
				res.kind              = rcsu_pkg::KindSample;
				res.channel_id        = channel;
				res.data_flavor       = flavor[1:0];
				res.cap_id            = capid;
				res.start_of_interest = w[14];
				res.adc_value         = w[7:0];
				res.tdc_leading       = w[13:8];
				res.sample_index      = count;
				if (count != 8'hFF)
					count = count + 8'd1;
			end else if (flavor == rcsu_pkg::FlavorPair) begin
				if (!held_valid) begin
					held_word  = w;
					held_valid = 1'b1;
				end else begin
					res_valid             = 1'b1;
					res.kind              = rcsu_pkg::KindSample;
					res.channel_id        = channel;
					res.data_flavor       = rcsu_pkg::FlavorPair[1:0];
					res.cap_id            = w[13:12];
					res.start_of_interest = held_word_q[13];
					res.sample_ok         = held_word_q[12];
					res.adc_value         = held_word_q[7:0];
					res.tdc_leading       = w[5:0];
					res.tdc_trailing      = w[10:6];
					res.sample_index      = count;
					if (count != 8'hFF)
						count = count + 8'd1;
					held_valid = 1'b0;
				end
			end
		end else if (pos >= region_end) begin
			held_valid = 1'b0;
		end

		pos_d = (pos != rcsu_pkg::PosMax) ? pos + 1'b1 : pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			region_end_q   <= '0;
			version_good_q <= 1'b0;
			in_channel_q   <= 1'b0;
			held_valid_q   <= 1'b0;
			flavor_q       <= '0;
			channel_q      <= '0;
			capid_q        <= '0;
			held_word_q    <= '0;
			count_q        <= '0;
		end else if (fire) begin
			pos_q          <= pos_d;
			region_end_q   <= region_end;
			version_good_q <= version_good;
			in_channel_q   <= in_channel;
			held_valid_q   <= held_valid;
			flavor_q       <= flavor;
			channel_q      <= channel;
			capid_q        <= capid;
			held_word_q    <= held_word;
			count_q        <= count;
		end
	end

endmodule

// ===== rtl/readout_channel_sample_unpacker.sv =====
// Top level of the readout channel sample unpacker.
// Depends on rcsu_pkg and rcsu_core.
//
// Usage:
//   Slave channel (s_*) takes one 16-bit payload word per beat. s_tuser[0]
//   marks word 0 of a board payload; on that beat s_tdata[39:16] carries the
//   payload size in 64-bit words. Words 0..7 are the board header, word 6
//   holds the version; channel data runs from word 8 up to the trailer.
//   Master channel (m_*) delivers at most one result beat per input word:
//   a decoded sample (m_tuser = 0) or a stray-word error (m_tuser = 1).
//   Headers, the first word of a flavor-2 pair and skipped words give no beat.
// Timing:
//   One word per cycle sustained while m_tready is high. A word is registered at the input,
//   decoded by the core from that register, and its result lands in the output
//   register that drives m_tvalid.
// Reset:
//   arst_n clears all position and channel state; before the first marked
//   word no results are produced.
// Stall:
//   While m_tready is low and a result is waiting, the input register fills
//   and then s_tready drops; no beat is lost or repeated.
module readout_channel_sample_unpacker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [15:0] data_word, [39:16] payload_size
	input  logic [rcsu_pkg::InDataW-1:0]     s_tdata,
	// [0] first_word
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] channel_id, [9:8] data_flavor, [11:10] cap_id,
	// [12] start_of_interest, [13] sample_ok, [21:14] adc_value,
	// [27:22] tdc_leading, [32:28] tdc_trailing, [40:33] sample_index,
	// [47:41] zero
	output logic [rcsu_pkg::OutDataW-1:0]    m_tdata,
	// [0] kind
	output logic [0:0]                       m_tuser
);

	logic              valid_s1;
	rcsu_pkg::item_t   item_s1;
	logic              advance, fire;
	logic              res_valid;
	rcsu_pkg::result_t res;
	rcsu_pkg::result_t res_q;

	// advance the core whenever the output register is free or draining
	assign advance  = !m_tvalid || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_word    <= s_tdata[15:0];
			item_s1.payload_size <= s_tdata[39:16];
			item_s1.first_word   <= s_tuser[0];
		end
	end

	rcsu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register: load on a producing word, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid)
			res_q <= res;
	end

	assign m_tuser[0] = res_q.kind;
	assign m_tdata = {
		7'd0,
		res_q.sample_index,
		res_q.tdc_trailing,
		res_q.tdc_leading,
		res_q.adc_value,
		res_q.sample_ok,
		res_q.start_of_interest,
		res_q.cap_id,
		res_q.data_flavor,
		res_q.channel_id
	};

endmodule

// ===== tb/tb_readout_channel_sample_unpacker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for readout_channel_sample_unpacker: streams board payloads
// and compares each result beat with an in-bench decoder. Depends on rcsu_pkg and the RTL.
module tb_readout_channel_sample_unpacker;

	logic                                clk;
	logic                                arst_n   = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	// [15:0] data_word, [39:16] payload_size
	logic [rcsu_pkg::InDataW-1:0]        s_tdata  = '0;
	// [0] first_word
	logic [0:0]                          s_tuser  = '0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	// [7:0] channel_id, [9:8] data_flavor, [11:10] cap_id, [12] start_of_interest,
	// [13] sample_ok, [21:14] adc_value, [27:22] tdc_leading, [32:28] tdc_trailing,
	// [40:33] sample_index, [47:41] zero
	logic [rcsu_pkg::OutDataW-1:0]       m_tdata;
	// [0] kind
	logic [0:0]                          m_tuser;

	readout_channel_sample_unpacker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Decoder state, mirrors what the block tracks per payload.
	logic [rcsu_pkg::PosW-1:0] pos_cnt       = '0;
	logic [rcsu_pkg::PosW-1:0] trailer_start = '0;
	logic                      version_ok    = 1'b0;
	logic                      chan_open     = 1'b0;
	logic [2:0]                chan_flavor   = '0;
	logic [7:0]                chan_id       = '0;
	logic [1:0]                chan_cap      = '0;
	logic [15:0]               pair_word     = '0;
	logic                      pair_held     = 1'b0;
	logic [7:0]                samp_idx      = '0;

	rcsu_pkg::result_t pending_samples[$];   // decoded results still owed by the block
	logic [15:0]       pay_q[$];             // payload words staged for sending
	int unsigned       sent_words    = 0;    // words accepted by the block so far
	int unsigned       wrong_cnt     = 0;
	int unsigned       beat_cnt      = 0;
	bit                calm          = 1'b0; // no idling on either side while set

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops beats.
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Mostly short idle stretches, a few long ones.
	function automatic int unsigned stall_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned pick_gap();
		if (calm || $urandom_range(0, 99) < 65)
			return 0;
		return stall_len();
	endfunction

	// Decode one accepted word and queue the result it should cause, if any.
	task automatic unpack_word(input logic [15:0] w, input logic first,
			input logic [23:0] size);
		rcsu_pkg::result_t         s;
		logic [rcsu_pkg::PosW-1:0] p;
		bit                        got_sample;
		s = '0;
		got_sample = 0;
		if (first) begin
			// restart the payload; region ends where the 64-bit trailer begins
			pos_cnt = '0;
			trailer_start = (size != '0) ? {size - 24'd1, 2'b00} : '0;
			version_ok = 1'b0;
			chan_open = 1'b0;
			pair_held = 1'b0;
			samp_idx = '0;
		end
		p = pos_cnt;
		if (p == rcsu_pkg::VersionPos)
			version_ok = (w[15:12] == rcsu_pkg::VersionGood);
		if (p >= rcsu_pkg::RegionStart && p < trailer_start && version_ok) begin
			if (w[15]) begin
				chan_open = 1'b1;
				chan_flavor = w[14:12];
				chan_id = w[7:0];
				chan_cap = w[9:8];
				pair_held = 1'b0;
				samp_idx = '0;
			end else if (!chan_open) begin
				// stray word: flag once, then drop until the next channel header
				s.kind = rcsu_pkg::KindStray;
				pending_samples.push_back(s);
				chan_open = 1'b1;
				chan_flavor = rcsu_pkg::FlavorSkip;
				pair_held = 1'b0;
			end else if (chan_flavor == rcsu_pkg::FlavorOne ||
					chan_flavor == rcsu_pkg::FlavorOneB) begin
				s.start_of_interest = w[14];
				s.tdc_leading = w[13:8];
				s.adc_value = w[7:0];
				s.cap_id = chan_cap;
				got_sample = 1;
			end else if (chan_flavor == rcsu_pkg::FlavorPair) begin
				if (!pair_held) begin
					pair_word = w;
					pair_held = 1'b1;
				end else begin
					s.start_of_interest = pair_word[13];
					s.sample_ok = pair_word[12];
					s.adc_value = pair_word[7:0];
					s.cap_id = w[13:12];
					s.tdc_trailing = w[10:6];
					s.tdc_leading = w[5:0];
					pair_held = 1'b0;
					got_sample = 1;
				end
			end
		end else if (p >= trailer_start) begin
			pair_held = 1'b0;
		end
		if (got_sample) begin
			s.kind = rcsu_pkg::KindSample;
			s.channel_id = chan_id;
			s.data_flavor = chan_flavor[1:0];
			s.sample_index = samp_idx;
			if (samp_idx != 8'hFF)
				samp_idx = samp_idx + 1'b1;
			pending_samples.push_back(s);
		end
		if (pos_cnt != rcsu_pkg::PosMax)
			pos_cnt = pos_cnt + 1'b1;
	endtask

	// Offer one word and hold it until the block takes the beat.
	task automatic send_word(input logic [15:0] w, input logic first, input logic [23:0] size);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {size, w};
		s_tuser <= first;
		do @(posedge clk); while (s_tready !== 1'b1);
		sent_words++;
		unpack_word(w, first, size);
	endtask

	// Send the staged words as one payload; size only travels on the marked beat.
	task automatic send_payload(input logic [23:0] size);
		foreach (pay_q[i])
			send_word(pay_q[i], i == 0, (i == 0) ? size : 24'($urandom));
		pay_q.delete();
	endtask

	// Hold off the sender until the block has delivered everything owed.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0) @(posedge clk);
	endtask

	task automatic board_header(input bit ver_ok);
		logic [3:0] nib;
		nib = ver_ok ? rcsu_pkg::VersionGood : 4'($urandom_range(2, 16));
		repeat (6) pay_q.push_back(16'($urandom));
		pay_q.push_back({nib, 12'($urandom)});
		pay_q.push_back(16'($urandom));
	endtask

	function automatic logic [15:0] chan_header(input logic [2:0] flv, input logic [1:0] cap,
			input logic [7:0] ch);
		logic [1:0] spare;
		spare = 2'($urandom);
		return {1'b1, flv, spare, cap, ch};
	endfunction

	function automatic logic [15:0] rand_data_word();
		return {1'b0, 15'($urandom)};
	endfunction

	// Words before any marked word: region end is still zero, expect silence.
	task automatic test_before_first_word();
		send_word(16'h0000, 1'b0, 24'hFFFFFF);
		send_word(16'h8123, 1'b0, 24'h000000);
		drain_results();
	endtask

	// One payload that walks through every flavor class and the corner cases.
	task automatic test_mixed_flavors();
		logic [15:0] region [20] = '{
			16'h0000,  // stray word where a header is required
			16'h7FFF,  // dropped after the stray
			16'h83FF,  // flavor 0, capid 3, channel 255
			16'h7FFF,  // all-ones sample
			16'h0000,  // all-zeros sample
			16'h9000,  // flavor 1, capid 0, channel 0
			16'h4155,
			16'hA05A,  // flavor 2
			16'h3FFF, 16'h3FFF,  // full pair
			16'h1234,  // odd leftover, dropped at next header
			16'hB311,  // flavor 3, skipped
			16'h7ABC,
			16'hF2EE,  // flavor 7, skipped
			16'hA0C3,  // flavor 2 again
			16'h2001,  // odd leftover at region end
			16'h0FFF, 16'hFFFF, 16'h8000, 16'h5555  // trailer, ignored
		};
		board_header(1);
		foreach (region[i])
			pay_q.push_back(region[i]);
		pay_q.push_back(16'h0001);  // past the trailer
		send_payload(24'd7);
		drain_results();
	endtask

	// Version nibble wrong: channel data must be ignored.
	task automatic test_bad_version();
		board_header(0);
		pay_q.push_back(16'h8001);
		pay_q.push_back(16'h0123);
		pay_q.push_back(16'h1234);
		pay_q.push_back(16'h7000);
		send_payload(24'd4);
		drain_results();
	endtask

	// Sizes 0, 1 and 2 leave no channel region at all.
	task automatic test_small_payloads();
		for (int unsigned sz = 0; sz < 3; sz++) begin
			board_header(1);
			pay_q.push_back(16'h0000);
			pay_q.push_back(16'h8005);
			send_payload(24'(sz));
		end
		drain_results();
	endtask

	// Largest declared size; cut short by the next payload.
	task automatic test_huge_payload();
		board_header(1);
		pay_q.push_back(chan_header(rcsu_pkg::FlavorOneB, 2'd1, 8'h3C));
		pay_q.push_back(rand_data_word());
		pay_q.push_back(rand_data_word());
		send_payload(24'hFFFFFF);
		drain_results();
	endtask

	// Long flavor 0/1 channel so the sample index pins at 255.
	task automatic test_index_saturation();
		board_header(1);
		pay_q.push_back(chan_header(3'($urandom_range(0, 1)), 2'($urandom), 8'($urandom)));
		repeat (270) pay_q.push_back(rand_data_word());
		pay_q.push_back(chan_header(rcsu_pkg::FlavorPair, 2'($urandom), 8'($urandom)));
		repeat (4) pay_q.push_back(rand_data_word());
		repeat (4) pay_q.push_back(16'($urandom));
		send_payload(24'd72);  // region ends exactly at word 284
		drain_results();
	endtask

	// Well-formed payloads with random content, plus some bad, short or overlong ones.
	task automatic random_payload();
		int unsigned n64, rend, n, cut;
		logic [2:0]  flv;
		n64 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
		rend = (n64 > 0) ? 4 * n64 - 4 : 0;
		board_header($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) pay_q.push_back(rand_data_word());
		while (pay_q.size() < rend) begin
			flv = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(3, 7))
			                                  : 3'($urandom_range(0, 2));
			pay_q.push_back(chan_header(flv, 2'($urandom), 8'($urandom)));
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
			repeat (n) pay_q.push_back(rand_data_word());
		end
		// trim the last channel back to the region end
		while (pay_q.size() > rend && pay_q.size() > 8)
			void'(pay_q.pop_back());
		repeat (4) pay_q.push_back(16'($urandom));
		if ($urandom_range(0, 6) == 0)
			repeat ($urandom_range(1, 3)) pay_q.push_back(16'($urandom));
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, pay_q.size());
			while (pay_q.size() > cut)
				void'(pay_q.pop_back());
		end
		send_payload(24'(n64));
	endtask

	// Random payloads until about 750 words have gone in over the whole run.
	task automatic test_random_payloads();
		while (sent_words < 750) begin
			calm = ($urandom_range(0, 4) == 0);
			random_payload();
			if ($urandom_range(0, 7) == 0)
				drain_results();
		end
		calm = 1'b0;
		drain_results();
	endtask

	// Receiver side: random back-pressure, off during calm stretches.
	initial begin : drive_ready
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				m_tready <= 1'b0;
				hold = hold - 1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				hold = stall_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic report_wrong(input string what, input logic [7:0] got, input logic [7:0] want);
		wrong_cnt++;
		if (wrong_cnt <= 50)
			$display("%0t: result beat %0d, %s: got %0h, want %0h", $time, beat_cnt, what, got,
				want);
	endtask

	task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_wrong(what, got, want);
	endtask

	// Compare each result beat with the oldest pending decode.
	always @(posedge clk) begin : check_beats
		rcsu_pkg::result_t want;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (pending_samples.size() == 0) begin
				report_wrong("beat with nothing pending", 8'(m_tuser), 8'h00);
			end else begin
				want = pending_samples.pop_front();
				check_field("kind", 8'(m_tuser[0]), 8'(want.kind));
				check_field("channel_id", m_tdata[7:0], want.channel_id);
				check_field("data_flavor", 8'(m_tdata[9:8]), 8'(want.data_flavor));
				check_field("cap_id", 8'(m_tdata[11:10]), 8'(want.cap_id));
				check_field("start_of_interest", 8'(m_tdata[12]), 8'(want.start_of_interest));
				check_field("sample_ok", 8'(m_tdata[13]), 8'(want.sample_ok));
				check_field("adc_value", m_tdata[21:14], want.adc_value);
				check_field("tdc_leading", 8'(m_tdata[27:22]), 8'(want.tdc_leading));
				check_field("tdc_trailing", 8'(m_tdata[32:28]), 8'(want.tdc_trailing));
				check_field("sample_index", m_tdata[40:33], want.sample_index);
			end
			beat_cnt++;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_first_word();
		test_mixed_flavors();
		test_bad_version();
		test_small_payloads();
		test_huge_payload();
		test_index_saturation();
		test_random_payloads();
		// let the two-stage pipeline settle before judging
		repeat (8) @(posedge clk);
		if (wrong_cnt == 0 && pending_samples.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== readout_channel_sample_unpacker.f =====
rtl/rcsu_pkg.sv
rtl/rcsu_core.sv
rtl/readout_channel_sample_unpacker.sv
tb/tb_readout_channel_sample_unpacker.sv
